// ===== rtl/atkx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atkx_pkg
// Types, constants and helper functions shared by the keystream XOR core.
// ----------------------------------------------------------------------------
package atkx_pkg;

    localparam int KEY_BYTES  = 32;
    localparam int PHASE_MOD  = 29;
    localparam int KEY_WORD_W = 64;
    localparam int KEY_WORDS  = KEY_BYTES / (KEY_WORD_W / 8);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KEY_WORD_W;
    localparam int START_W    = 32;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_WORD_0  = 3'd0,
        CFG_KEY_WORD_1  = 3'd1,
        CFG_KEY_WORD_2  = 3'd2,
        CFG_KEY_WORD_3  = 3'd3,
        CFG_START_INDEX = 3'd4
    } t_cfg_reg;

    typedef logic [$clog2(KEY_WORDS)-1:0] t_key_addr;
    typedef logic [KEY_WORD_W-1:0]        t_key_word;

    // Keystream position of one byte: index mod 256 and index mod 29.
    typedef struct packed {
        logic [7:0] idx;
        logic [4:0] ph;
    } t_pos;

    // Residue of a 32-bit value mod 29. Fold bytes with 256 = 24 (mod 29),
    // then finish with a reciprocal multiply (2^14 / 29 rounded up) and
    // one correcting subtract.
    function automatic logic [4:0] mod29(input logic [START_W-1:0] v);
        logic [14:0] s1;
        logic [11:0] s2;
        logic [9:0]  s3;
        logic [18:0] prod;
        logic [4:0]  q;
        logic [9:0]  r;
        // 256^1 = 24, 256^2 = 25, 256^3 = 20 (mod 29)
        s1 = 15'(v[7:0]) + 15'(v[15:8]) * 15'd24
           + 15'(v[23:16]) * 15'd25 + 15'(v[31:24]) * 15'd20;
        s2 = 12'(s1[7:0]) + 12'(s1[14:8]) * 12'd24;
        s3 = 10'(s2[7:0]) + 10'(s2[11:8]) * 10'd24;
        prod = 19'(s3) * 19'd565;
        q = prod[18:14];
        r = s3 - 10'(q) * 10'(PHASE_MOD);
        if (r >= 10'(PHASE_MOD)) begin
            r = r - 10'(PHASE_MOD);
        end
        return r[4:0];
    endfunction

endpackage

// ===== rtl/atkx_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atkx_in_if
// Input word channel: one data byte with run start and last flags.
// ----------------------------------------------------------------------------
interface atkx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       run_start;
    logic       last_in;

    modport source (output valid, output data_in, output run_start, output last_in,
                    input ready);
    modport sink   (input valid, input data_in, input run_start, input last_in,
                    output ready);
endinterface

// ===== rtl/atkx_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atkx_out_if
// Output word channel: one ciphered byte with its last flag.
// ----------------------------------------------------------------------------
interface atkx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       last_out;

    modport source (output valid, output data_out, output last_out, input ready);
    modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

// ===== rtl/atkx_idx.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atkx_idx
// Keystream index tracker: low index byte, mod-29 phase and run restart.
// ----------------------------------------------------------------------------
module atkx_idx (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [atkx_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [atkx_pkg::START_W-1:0]   i_cfg_start,
    input  logic                           i_adv,
    input  logic                           i_run_start,
    output atkx_pkg::t_pos                 o_pos
);
    import atkx_pkg::*;

    logic [7:0] r_start_low;
    logic [4:0] r_start_ph;
    logic [7:0] r_index_low;
    logic [4:0] r_phase;
    t_pos       n_pos;

    // Position used by the word being accepted now.
    always_comb begin
        if (i_run_start) begin
            o_pos.idx = r_start_low;
            o_pos.ph  = r_start_ph;
        end else begin
            o_pos.idx = r_index_low;
            o_pos.ph  = r_phase;
        end
        n_pos.idx = o_pos.idx + 8'd1;
        n_pos.ph  = (o_pos.ph == 5'(PHASE_MOD - 1)) ? 5'd0 : o_pos.ph + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_low <= '0;
            r_start_ph  <= '0;
            r_index_low <= '0;
            r_phase     <= '0;
        end else begin
            // Reduce the start index once, at write time.
            if (i_cfg_we && i_cfg_idx == CFG_START_INDEX) begin
                r_start_low <= i_cfg_start[7:0];
                r_start_ph  <= mod29(i_cfg_start);
            end
            if (i_adv) begin
                r_index_low <= n_pos.idx;
                r_phase     <= n_pos.ph;
            end
        end
    end

endmodule

// ===== rtl/atkx_key.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atkx_key
// Key store: four 64-bit words, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module atkx_key (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [atkx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [atkx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_rd_en,
    input  atkx_pkg::t_key_addr             i_addr_a,
    input  atkx_pkg::t_key_addr             i_addr_b,
    output atkx_pkg::t_key_word             o_word_a,
    output atkx_pkg::t_key_word             o_word_b
);
    import atkx_pkg::*;

    t_key_word r_mem [KEY_WORDS];
    t_key_word r_word_a;
    t_key_word r_word_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_WORD_0: r_mem[0] <= i_cfg_data;
                CFG_KEY_WORD_1: r_mem[1] <= i_cfg_data;
                CFG_KEY_WORD_2: r_mem[2] <= i_cfg_data;
                CFG_KEY_WORD_3: r_mem[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_word_a <= r_mem[i_addr_a];
            r_word_b <= r_mem[i_addr_b];
        end
    end

    assign o_word_a = r_word_a;
    assign o_word_b = r_word_b;

endmodule

// ===== rtl/atkx_ks.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atkx_ks
// Keystream byte: select two key bytes, multiply, add the index, XOR data.
// ----------------------------------------------------------------------------
module atkx_ks (
    input  atkx_pkg::t_pos      i_pos,
    input  atkx_pkg::t_key_word i_word_a,
    input  atkx_pkg::t_key_word i_word_b,
    input  logic [7:0]          i_data,
    output logic [7:0]          o_data
);
    import atkx_pkg::*;

    logic [7:0]  key_a;
    logic [7:0]  key_b;
    logic [15:0] prod;
    logic [7:0]  ks;

    always_comb begin
        key_a = i_word_a[{i_pos.idx[2:0], 3'b000} +: 8];
        key_b = i_word_b[{i_pos.ph[2:0], 3'b000} +: 8];
        prod  = 16'(key_a) * 16'(key_b);
        ks    = i_pos.idx + (prod[7:0] & BYTE_MASK);
        o_data = i_data ^ ks;
    end

endmodule

// ===== rtl/archive_toc_keystream_xor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_toc_keystream_xor_core
// Byte-stream XOR cipher with a 32-byte key and a running keystream index.
// ----------------------------------------------------------------------------
// Usage:
//   i_in_ch  carries one byte per word with run_start and last_in flags.
//   o_out_ch returns one word per input word: the ciphered byte and last_out.
//   Encrypt and decrypt are the same operation.
//   The config port writes key words 0..3 and start_index; write only while
//   no words are in flight. Indexes beyond start_index are ignored.
// Timing:
//   Two register stages. A word accepted into stage one moves on to the
//   stage-two result register, which drives o_out_ch, once stage two is
//   free or being drained. Throughput is one word per cycle, since both
//   stages advance together while the sink is ready.
// Reset:
//   Synchronous, active low. Clears the key, start index, index and phase
//   and empties both stages.
// Stall:
//   When o_out_ch.ready is low the result holds; stage one still takes a
//   new word if it is empty, then i_in_ch.ready drops until the sink drains.
// ----------------------------------------------------------------------------
module archive_toc_keystream_xor_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    atkx_in_if.sink                         i_in_ch,
    atkx_out_if.source                      o_out_ch,
    input  logic                            i_cfg_we,
    input  logic [atkx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [atkx_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import atkx_pkg::*;

    // Handshake and stage control
    logic s2_ready;
    logic s1_go;
    logic in_ready;
    logic in_acc;

    t_pos      cur_pos;
    t_key_word word_a;
    t_key_word word_b;
    logic [7:0] ks_data;

    // Stage one: position and key words for the accepted byte
    logic       r_s1_v;
    t_pos       r_s1_pos;
    logic [7:0] r_s1_data;
    logic       r_s1_last;

    // Stage two: result register
    logic       r_s2_v;
    logic [7:0] r_s2_data;
    logic       r_s2_last;

    assign s2_ready = !r_s2_v || o_out_ch.ready;
    assign s1_go    = r_s1_v && s2_ready;
    assign in_ready = !r_s1_v || s2_ready;
    assign in_acc   = i_in_ch.valid && in_ready;

    assign i_in_ch.ready     = in_ready;
    assign o_out_ch.valid    = r_s2_v;
    assign o_out_ch.data_out = r_s2_data;
    assign o_out_ch.last_out = r_s2_last;

    // Track the running index; advance once per accepted word.
    atkx_idx u_idx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_start (i_cfg_data[START_W-1:0]),
        .i_adv       (in_acc),
        .i_run_start (i_in_ch.run_start),
        .o_pos       (cur_pos)
    );

    // Read both key words for this position; data lands with stage one.
    atkx_key u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rd_en    (in_acc),
        .i_addr_a   (cur_pos.idx[4:3]),
        .i_addr_b   (cur_pos.ph[4:3]),
        .o_word_a   (word_a),
        .o_word_b   (word_b)
    );

    atkx_ks u_ks (
        .i_pos    (r_s1_pos),
        .i_word_a (word_a),
        .i_word_b (word_b),
        .i_data   (r_s1_data),
        .o_data   (ks_data)
    );

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go) begin
                r_s2_v <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    // Payload: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pos  <= cur_pos;
            r_s1_data <= i_in_ch.data_in;
            r_s1_last <= i_in_ch.last_in;
        end
        if (s1_go) begin
            r_s2_data <= ks_data;
            r_s2_last <= r_s1_last;
        end
    end

endmodule

// ===== rtl/atkx_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atkx_chk
// Port-level checks on the keystream XOR core, bound to the top level.
// ----------------------------------------------------------------------------
module atkx_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_data,
    input logic       i_out_last
);
    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_cnt;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_data) && $stable(i_out_last))
        else $error("stalled output word changed");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 2'd0)
        else $error("output word without a matching input word");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("more words in flight than stages");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !i_out_ready |-> !i_in_ready)
        else $error("input taken while both stages are full");

endmodule

bind archive_toc_keystream_xor_core atkx_chk u_atkx_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_data  (o_out_ch.data_out),
    .i_out_last  (o_out_ch.last_out)
);

// ===== test/tb_archive_toc_keystream_xor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_archive_toc_keystream_xor_core
// Self-checking bench for the keystream XOR core. A local model of the
// keystream position (index mod 256, index mod 29) and of the key and start
// registers predicts each ciphered word as input words are accepted; a
// checker compares every output word with the oldest prediction. Directed
// tests cover reset state, field extremes, index and phase wrap, runs that
// continue past the last flag, register updates between runs and writes to
// unused register indexes; random runs with all-ones, all-zero and random
// keys and start indexes follow, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module tb_archive_toc_keystream_xor_core;

    import atkx_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP  = '1;
    localparam int                   MAX_REPORTS  = 10;
    localparam int                   DRAIN_CYCLES = 8;
    localparam int                   PHASE_WORDS  = 240;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_cipher_word;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    atkx_in_if  in_ch ();
    atkx_out_if out_ch ();

    archive_toc_keystream_xor_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Model of the block: registers and keystream position.
    t_key_word     key_model [KEY_WORDS];
    logic [31:0]   start_model;
    logic [7:0]    idx_model;
    logic [4:0]    phase_model;

    t_cipher_word  cipher_expected [$];
    int            fail_cnt;
    bit            no_idle;

    // ------------------------------------------------------------------------
    // Clock: 12 ns period.
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #20000000;
        $display("** archive_toc_keystream_xor_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Keystream prediction
    // ------------------------------------------------------------------------
    function automatic logic [7:0] key_byte_at(input logic [4:0] pos);
        return key_model[pos[4:3]][pos[2:0]*8 +: 8];
    endfunction

    // Keystream byte at the current position: index plus the low byte of
    // the product of the key bytes selected by index mod 32 and index mod 29.
    function automatic logic [7:0] predict_keystream(input logic [7:0] idx,
                                                     input logic [4:0] ph);
        logic [15:0] prod;
        prod = 16'(key_byte_at(idx[4:0])) * 16'(key_byte_at(ph));
        return idx + prod[7:0];
    endfunction

    // Mirror the block at each edge: apply register writes, predict accepted
    // words, then check accepted output words against the oldest prediction.
    // All reads happen before the edge's updates land, so order is fixed.
    always @(posedge i_clk) begin
        t_cipher_word exp_w;
        t_cipher_word got_w;
        if (!i_rst_n) begin
            for (int w = 0; w < KEY_WORDS; w++) begin
                key_model[w] <= '0;
            end
            start_model <= '0;
            idx_model   <= '0;
            phase_model <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_WORD_0:  key_model[0] <= i_cfg_data;
                    CFG_KEY_WORD_1:  key_model[1] <= i_cfg_data;
                    CFG_KEY_WORD_2:  key_model[2] <= i_cfg_data;
                    CFG_KEY_WORD_3:  key_model[3] <= i_cfg_data;
                    CFG_START_INDEX: start_model  <= i_cfg_data[START_W-1:0];
                    default: ;  // unused index: drop the write
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                logic [7:0] cur_idx;
                logic [4:0] cur_ph;
                cur_idx = idx_model;
                cur_ph  = phase_model;
                // Restart the position at the configured start index.
                if (in_ch.run_start) begin
                    cur_idx = start_model[7:0];
                    cur_ph  = 5'(start_model % 32'(PHASE_MOD));
                end
                exp_w.data = in_ch.data_in ^ predict_keystream(cur_idx, cur_ph);
                exp_w.last = in_ch.last_in;
                cipher_expected.push_back(exp_w);
                // Advance: index wraps mod 256, phase from 28 back to 0.
                idx_model   <= cur_idx + 8'd1;
                phase_model <= (cur_ph == 5'(PHASE_MOD - 1)) ? 5'd0 : cur_ph + 5'd1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got_w.data = out_ch.data_out;
                got_w.last = out_ch.last_out;
                if (cipher_expected.size() == 0) begin
                    if (fail_cnt < MAX_REPORTS) begin
                        $display("%0t: unexpected word data=%02h last=%0b",
                                 $realtime, got_w.data, got_w.last);
                    end
                    fail_cnt++;
                end else begin
                    exp_w = cipher_expected.pop_front();
                    if (got_w !== exp_w) begin
                        if (fail_cnt < MAX_REPORTS) begin
                            $display("%0t: mismatch data exp=%02h got=%02h last exp=%0b got=%0b",
                                     $realtime, exp_w.data, got_w.data,
                                     exp_w.last, got_w.last);
                        end
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Gap lengths: mostly none or short, a few long.
    // ------------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Output sink: bursts of ready broken by random stalls.
    initial begin
        int burst;
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            out_ch.ready <= 1'b1;
            burst = $urandom_range(1, 24);
            repeat (burst) @(posedge i_clk);
            stall = no_idle ? 0 : idle_len();
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Write one register; hold the strobe for a single edge.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_key(input t_key_word k0, input t_key_word k1,
                            input t_key_word k2, input t_key_word k3);
        cfg_write(CFG_KEY_WORD_0, k0);
        cfg_write(CFG_KEY_WORD_1, k1);
        cfg_write(CFG_KEY_WORD_2, k2);
        cfg_write(CFG_KEY_WORD_3, k3);
    endtask

    function automatic t_key_word rand_key_word();
        return {$urandom, $urandom};
    endfunction

    // Send one word and wait for the handshake. Valid stays high after
    // acceptance unless a gap follows, so back-to-back words never toggle it.
    task automatic send_word(input logic [7:0] data, input logic start,
                             input logic last);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.data_in   <= data;
        in_ch.run_start <= start;
        in_ch.last_in   <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        gap = no_idle ? 0 : idle_len();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold until every predicted word has come back.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (cipher_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A well-formed run: run_start on the first word, last on the final one.
    task automatic send_run(input int len);
        for (int i = 0; i < len; i++) begin
            send_word(8'($urandom), i == 0, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // No run start after reset: zero key, index counts from zero.
    task automatic test_reset_state();
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hA5, 1'b0, 1'b1);
        wait_idle();
    endtask

    // All-ones key and start index, extreme data bytes.
    task automatic test_field_extremes();
        load_key('1, '1, '1, '1);
        cfg_write(CFG_START_INDEX, CFG_DATA_W'(32'hFFFF_FFFF));
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        wait_idle();
    endtask

    // Index wrap at 255 and phase wrap at 28, random key.
    task automatic test_position_wrap();
        load_key(rand_key_word(), rand_key_word(), rand_key_word(), rand_key_word());
        cfg_write(CFG_START_INDEX, CFG_DATA_W'(254));
        send_run(4);
        wait_idle();
        cfg_write(CFG_START_INDEX, CFG_DATA_W'(PHASE_MOD - 1));
        send_run(3);
        wait_idle();
        cfg_write(CFG_START_INDEX, CFG_DATA_W'(PHASE_MOD * 7));
        send_run(2);
        wait_idle();
    endtask

    // Words after the last one keep counting; a new start index waits for
    // the next run start, a new key word applies on the next word.
    task automatic test_run_continuation();
        cfg_write(CFG_START_INDEX, CFG_DATA_W'($urandom));
        send_run(2);
        send_word(8'($urandom), 1'b0, 1'b0);
        send_word(8'($urandom), 1'b0, 1'b1);
        wait_idle();
        cfg_write(CFG_START_INDEX, CFG_DATA_W'($urandom));
        cfg_write(CFG_KEY_WORD_0, rand_key_word());
        send_word(8'($urandom), 1'b0, 1'b0);
        send_word(8'($urandom), 1'b1, 1'b1);
        wait_idle();
    endtask

    // Writes to indexes past the register list change nothing.
    task automatic test_unused_registers();
        for (int idx = int'(CFG_START_INDEX) + 1; idx <= int'(CFG_IDX_TOP); idx++) begin
            cfg_write(CFG_IDX_W'(idx), rand_key_word());
        end
        send_word(8'($urandom), 1'b0, 1'b0);
        send_word(8'($urandom), 1'b0, 1'b1);
        wait_idle();
    endtask

    // Random runs over several register settings. Most traffic is
    // well-formed runs; the rest is flag noise and runs continued without
    // a start. One phase runs without gaps, and each phase holds the sender
    // once until the output side has drained.
    task automatic test_random_runs();
        int sent;
        int len;
        int kind;
        bit paused;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    load_key('1, '1, '1, '1);
                    cfg_write(CFG_START_INDEX, CFG_DATA_W'(32'hFFFF_FFFF));
                end
                1: begin
                    load_key('0, '0, '0, '0);
                    cfg_write(CFG_START_INDEX, '0);
                end
                default: begin
                    load_key(rand_key_word(), rand_key_word(),
                             rand_key_word(), rand_key_word());
                    cfg_write(CFG_START_INDEX, CFG_DATA_W'($urandom));
                end
            endcase
            no_idle = (phase == 3);
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_WORDS) begin
                kind = $urandom_range(0, 99);
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(1, 16);
                if (kind < 82) begin
                    send_run(len);
                end else if (kind < 92) begin
                    // Flag noise: random start and last on every word.
                    for (int i = 0; i < len; i++) begin
                        send_word(8'($urandom), 1'($urandom), 1'($urandom));
                    end
                end else begin
                    // Continue from the previous run without a start.
                    for (int i = 0; i < len; i++) begin
                        send_word(8'($urandom), 1'b0, i == len - 1);
                    end
                end
                sent += len;
                if (!paused && sent >= PHASE_WORDS / 2) begin
                    paused = 1'b1;
                    wait_idle();
                end
            end
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        fail_cnt        = 0;
        no_idle         = 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.data_in   <= '0;
        in_ch.run_start <= 1'b0;
        in_ch.last_in   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_field_extremes();
        test_position_wrap();
        test_run_continuation();
        test_unused_registers();
        test_random_runs();

        wait_idle();
        if (fail_cnt == 0 && cipher_expected.size() == 0) begin
            $display("** archive_toc_keystream_xor_core: PASSED **");
        end else begin
            $display("** archive_toc_keystream_xor_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/atkx_pkg.sv
rtl/atkx_in_if.sv
rtl/atkx_out_if.sv
rtl/atkx_idx.sv
rtl/atkx_key.sv
rtl/atkx_ks.sv
rtl/archive_toc_keystream_xor_core.sv
rtl/atkx_chk.sv
test/tb_archive_toc_keystream_xor_core.sv
